// File: rtl/utf8_validate_count_macros.svh
// ----------------------------------------------------------------------------
// utf8_validate_count_macros
// Assertion macros used by utf8_validate_count.
// ----------------------------------------------------------------------------
// Each macro expects clk and rst_n in scope.
`ifndef UTF8_VALIDATE_COUNT_MACROS_SVH
`define UTF8_VALIDATE_COUNT_MACROS_SVH

// Condition that must hold on every clock edge outside reset
`define UVC_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent on one edge implies the consequent on the next edge
`define UVC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/uvc_pkg.sv
// ----------------------------------------------------------------------------
// uvc_pkg
// Status codes, byte-range and code-point constants for the UTF-8 validator/counter.
// ----------------------------------------------------------------------------
package uvc_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_VALID     = 2'd0,
        STATUS_MALFORMED = 2'd1,
        STATUS_TOO_LONG  = 2'd2
    } status_t;

    // Lead and continuation byte ranges
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD2_MIN   = 8'hC2;
    localparam logic [7:0] LEAD2_MAX   = 8'hDF;
    localparam logic [7:0] LEAD3_MIN   = 8'hE0;
    localparam logic [7:0] LEAD3_MAX   = 8'hEF;
    localparam logic [7:0] LEAD4_MIN   = 8'hF0;
    localparam logic [7:0] LEAD4_MAX   = 8'hF4;
    localparam logic [1:0] CONT_TAG    = 2'b10;

    // Code point limits
    localparam logic [20:0] CTRL_LIMIT   = 21'h00020;
    localparam logic [20:0] DEL_CHAR     = 21'h0007F;
    localparam logic [20:0] MIN_THREE    = 21'h00800;
    localparam logic [20:0] SURR_MIN     = 21'h0D800;
    localparam logic [20:0] SURR_MAX     = 21'h0DFFF;
    localparam logic [20:0] MIN_FOUR     = 21'h10000;
    localparam logic [20:0] MAX_CODE_PT  = 21'h10FFFF;

    // Code point counter saturation value
    localparam logic [7:0] POINT_SAT = 8'hFF;

endpackage

// File: rtl/utf8_validate_count.sv
// The result of a final byte is registered into the output buffer when its transaction is accepted.
// Throughput: one byte per cycle while in_stall is low; the decode and range checks sit in one register stage.
// A two-entry output buffer lets input continue while one result waits on out_stall.
// in_stall rises only when both output entries hold results.
// Reset (rst_n low, asynchronous) clears the decoder state and empties the output buffer.
// ----------------------------------------------------------------------------
// utf8_validate_count
// Validates a UTF-8 string taken one byte per transaction and reports a
// status and, for a valid string, the code-point count on the final transaction.
// ----------------------------------------------------------------------------
`include "utf8_validate_count_macros.svh"

module utf8_validate_count
    import uvc_pkg::*;
#(
    parameter int MAX_LEN = 128
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] text_byte,
    input  logic       last,
    input  logic       empty_req,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic [7:0] code_points
);

    // Byte counter saturates at MAX_LEN + 1
    localparam int CNT_W = $clog2(MAX_LEN + 2);
    localparam logic [CNT_W-1:0] MAX_LEN_C = CNT_W'(MAX_LEN);

    // Decoder state
    logic [1:0]       pend_reg, pend_next;
    logic [1:0]       seq_len_reg, seq_len_next;
    logic [20:0]      cp_reg, cp_next;
    logic [7:0]       point_cnt_reg, point_cnt_next;
    logic [CNT_W-1:0] byte_cnt_reg, byte_cnt_next;
    logic             err_reg, err_next;

    // Output buffer: main entry drives the port, skid entry catches overflow
    logic             main_valid_reg, skid_valid_reg;
    status_t          main_status_reg, skid_status_reg;
    logic [7:0]       main_points_reg, skid_points_reg;

    logic             in_accept;
    logic             out_pop;
    logic             final_item;
    logic             push;
    logic [20:0]      cp_shift;
    logic             seq_bad;
    status_t          res_status;
    logic [7:0]       res_points;

    assign in_stall   = skid_valid_reg;
    assign in_accept  = in_valid && !in_stall;
    assign out_valid  = main_valid_reg;
    assign out_pop    = main_valid_reg && !out_stall;
    assign status     = main_status_reg;
    assign code_points = main_points_reg;
    assign final_item = last || empty_req;
    assign push       = in_accept && final_item;

    // Continuation payload shifted into the partial code point
    assign cp_shift = {cp_reg[14:0], text_byte[5:0]};

    // Range checks on a completed multi-byte sequence
    always_comb
    begin
        seq_bad = 1'b0;
        if (seq_len_reg == 2'd2 &&
            (cp_shift < MIN_THREE || (cp_shift >= SURR_MIN && cp_shift <= SURR_MAX)))
            seq_bad = 1'b1;
        if (seq_len_reg == 2'd3 && (cp_shift < MIN_FOUR || cp_shift > MAX_CODE_PT))
            seq_bad = 1'b1;
        if (cp_shift < CTRL_LIMIT || cp_shift == DEL_CHAR)
            seq_bad = 1'b1;
    end

    // Per-byte decode
    always_comb
    begin
        pend_next      = pend_reg;
        seq_len_next   = seq_len_reg;
        cp_next        = cp_reg;
        point_cnt_next = point_cnt_reg;
        byte_cnt_next  = byte_cnt_reg;
        err_next       = err_reg;
        if (!empty_req)
        begin
            if (byte_cnt_reg <= MAX_LEN_C)
                byte_cnt_next = byte_cnt_reg + 1'b1;
            if (!err_reg)
            begin
                if (pend_reg == 2'd0)
                begin
                    priority if (text_byte < ASCII_LIMIT)
                    begin
                        if (text_byte < CTRL_LIMIT[7:0] || text_byte == DEL_CHAR[7:0])
                            err_next = 1'b1;
                        else if (point_cnt_reg != POINT_SAT)
                            point_cnt_next = point_cnt_reg + 1'b1;
                    end
                    else if (text_byte >= LEAD2_MIN && text_byte <= LEAD2_MAX)
                    begin
                        cp_next      = {16'd0, text_byte[4:0]};
                        pend_next    = 2'd1;
                        seq_len_next = 2'd1;
                    end
                    else if (text_byte >= LEAD3_MIN && text_byte <= LEAD3_MAX)
                    begin
                        cp_next      = {17'd0, text_byte[3:0]};
                        pend_next    = 2'd2;
                        seq_len_next = 2'd2;
                    end
                    else if (text_byte >= LEAD4_MIN && text_byte <= LEAD4_MAX)
                    begin
                        cp_next      = {18'd0, text_byte[2:0]};
                        pend_next    = 2'd3;
                        seq_len_next = 2'd3;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                else if (text_byte[7:6] != CONT_TAG)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    cp_next   = cp_shift;
                    pend_next = pend_reg - 1'b1;
                    if (pend_reg == 2'd1)
                    begin
                        if (seq_bad)
                            err_next = 1'b1;
                        else if (point_cnt_reg != POINT_SAT)
                            point_cnt_next = point_cnt_reg + 1'b1;
                        seq_len_next = 2'd0;
                        cp_next      = 21'd0;
                    end
                end
            end
        end
    end

    // Final status from the updated state
    always_comb
    begin
        res_points = 8'd0;
        priority if (byte_cnt_next > MAX_LEN_C)
            res_status = STATUS_TOO_LONG;
        else if (err_next || pend_next != 2'd0)
            res_status = STATUS_MALFORMED;
        else
        begin
            res_status = STATUS_VALID;
            res_points = point_cnt_next;
        end
    end

    // Decoder state registers; cleared after each final transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 2'd0;
            seq_len_reg   <= 2'd0;
            cp_reg        <= 21'd0;
            point_cnt_reg <= 8'd0;
            byte_cnt_reg  <= '0;
            err_reg       <= 1'b0;
        end
        else if (in_accept)
        begin
            if (final_item)
            begin
                pend_reg      <= 2'd0;
                seq_len_reg   <= 2'd0;
                cp_reg        <= 21'd0;
                point_cnt_reg <= 8'd0;
                byte_cnt_reg  <= '0;
                err_reg       <= 1'b0;
            end
            else
            begin
                pend_reg      <= pend_next;
                seq_len_reg   <= seq_len_next;
                cp_reg        <= cp_next;
                point_cnt_reg <= point_cnt_next;
                byte_cnt_reg  <= byte_cnt_next;
                err_reg       <= err_next;
            end
        end
    end

    // Output buffer valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_pop)
        begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            main_valid_reg <= 1'b1;
            skid_valid_reg <= main_valid_reg;
        end
    end

    // Output buffer payload
    always_ff @(posedge clk)
    begin
        if (out_pop)
        begin
            if (skid_valid_reg)
            begin
                main_status_reg <= skid_status_reg;
                main_points_reg <= skid_points_reg;
            end
            else if (push)
            begin
                main_status_reg <= res_status;
                main_points_reg <= res_points;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_status_reg <= res_status;
                skid_points_reg <= res_points;
            end
            else
            begin
                main_status_reg <= res_status;
                main_points_reg <= res_points;
            end
        end
    end

    // Checks
    `UVC_ASSERT(a_skid_needs_main, !skid_valid_reg || main_valid_reg,
        "skid entry full while main entry empty")
    `UVC_ASSERT(a_pend_within_len, pend_reg <= seq_len_reg,
        "more continuations pending than the sequence holds")
    `UVC_ASSERT_NEXT(a_clear_after_final, in_accept && final_item,
        byte_cnt_reg == '0 && pend_reg == 2'd0 && !err_reg,
        "decoder state not cleared after final transaction")
    `UVC_ASSERT_NEXT(a_skid_refills_main, out_pop && skid_valid_reg,
        main_valid_reg && !skid_valid_reg, "buffered result lost on drain")

endmodule
